// ===== design/scvc_pkg.sv =====
package scvc_pkg;

	// control modes
	localparam logic [1:0] MODE_CURRENT  = 2'd0;
	localparam logic [1:0] MODE_SPEED    = 2'd1;
	localparam logic [1:0] MODE_POSITION = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_KP    = 3'd1;
	localparam logic [2:0] REG_KI    = 3'd2;
	localparam logic [2:0] REG_KV    = 3'd3;
	localparam logic [2:0] REG_KD    = 3'd4;
	localparam logic [2:0] REG_RATED = 3'd5;
	localparam logic [2:0] REG_LEAD  = 3'd6;

	localparam logic [14:0] RATED_RESET = 15'd3000;
	localparam logic [15:0] LEAD_RESET  = 16'd256;

	// error clamp limits
	localparam logic [24:0] SPEED_ERR_LIMIT = 25'd1048576;
	localparam logic [24:0] POS_ERR_LIMIT   = 25'd3200;
	localparam logic [24:0] VEL_ERR_LIMIT   = 25'd4000;

	// control handed to the integrator stage
	typedef struct packed {
		logic       adv;
		logic       vld;
		logic       clr;
		logic [1:0] mode;
	} scvc_int_ctl_t;

	// symmetric saturation to +-lim
	function automatic logic signed [42:0] sat_sym(input logic signed [42:0] x,
		input logic [24:0] lim);
		logic signed [42:0] hi;
		hi = signed'(43'(lim));
		if (x > hi) begin
			return hi;
		end else if (x < -hi) begin
			return -hi;
		end
		return x;
	endfunction

endpackage

// ===== design/scvc_ifs.sv =====
interface scvc_tick_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measured_position;
	logic signed [31:0] measured_speed;
	logic signed [31:0] target_position;
	logic signed [31:0] target_speed;
	logic signed [15:0] target_current;
	logic               clear_integral;

	modport source (output valid, measured_position, measured_speed, target_position,
		target_speed, target_current, clear_integral, input ready);
	modport sink (input valid, measured_position, measured_speed, target_position,
		target_speed, target_current, clear_integral, output ready);
endinterface

interface scvc_drive_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive_current;
	logic signed [31:0] electrical_angle;
	logic               at_limit;

	modport source (output valid, drive_current, electrical_angle, at_limit, input ready);
	modport sink (input valid, drive_current, electrical_angle, at_limit, output ready);
endinterface

// ===== design/scvc_integrator.sv =====
module scvc_integrator import scvc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scvc_int_ctl_t        ctl,
	input  logic [14:0]          rated,
	input  logic signed [39:0]   incr,
	output logic signed [26:0]   acc_next
);

	logic [9:0]         spd_res_q;
	logic signed [26:0] spd_acc_q;
	logic [6:0]         pos_res_q;
	logic signed [26:0] pos_acc_q;

	logic [9:0]         res_sel;
	logic signed [26:0] acc_sel;
	logic signed [40:0] frac;
	logic signed [33:0] whole;
	logic signed [34:0] acc_sum;
	logic               is_speed;

	assign is_speed = (ctl.mode == MODE_SPEED);

	always_comb begin
		// clear flag acts before this tick's update
		if (ctl.clr) begin
			res_sel = '0;
			acc_sel = '0;
		end else if (is_speed) begin
			res_sel = spd_res_q;
			acc_sel = spd_acc_q;
		end else begin
			res_sel = {3'b000, pos_res_q};
			acc_sel = pos_acc_q;
		end
		frac = 41'(incr) + 41'(signed'({1'b0, res_sel}));
		if (is_speed) begin
			whole = 34'(signed'(frac[40:10]));
		end else begin
			whole = signed'(frac[40:7]);
		end
		acc_sum  = 35'(acc_sel) + 35'(whole);
		acc_next = 27'(sat_sym(43'(acc_sum), {rated, 10'b0}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_res_q <= '0;
			spd_acc_q <= '0;
			pos_res_q <= '0;
			pos_acc_q <= '0;
		end else if (ctl.adv && ctl.vld) begin
			if (ctl.mode == MODE_SPEED) begin
				spd_res_q <= frac[9:0];
				spd_acc_q <= acc_next;
			end else if (ctl.clr) begin
				spd_res_q <= '0;
				spd_acc_q <= '0;
			end
			if (ctl.mode == MODE_POSITION) begin
				pos_res_q <= frac[6:0];
				pos_acc_q <= acc_next;
			end else if (ctl.clr) begin
				pos_res_q <= '0;
				pos_acc_q <= '0;
			end
		end
	end

endmodule

// ===== design/stepper_current_vector_controller_top.sv =====
// a result passes the input register and stages 2 to 4 before it is valid in the stage 5 output register
// throughput: one beat per cycle while the output beat is not stalled; the integrator update loop closes within stage 4
// all stages advance together whenever the output register is empty or being taken
// reset (arst_n low, asynchronous): pipeline empty, integrators and previous
// speed error zero, registers at mode 0, gains 0, rated 3000, lead 256
module stepper_current_vector_controller_top import scvc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [15:0]         cfg_wdata,
	scvc_tick_if.sink           tick_in,
	scvc_drive_if.source        drive_out
);

	// configuration registers
	logic [1:0]  mode_q;
	logic [15:0] kp_q;
	logic [15:0] ki_q;
	logic [15:0] kv_q;
	logic [15:0] kd_q;
	logic [14:0] rated_q;
	logic [15:0] lead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_CURRENT;
			kp_q    <= '0;
			ki_q    <= '0;
			kv_q    <= '0;
			kd_q    <= '0;
			rated_q <= RATED_RESET;
			lead_q  <= LEAD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:  mode_q  <= cfg_wdata[1:0];
				REG_KP:    kp_q    <= cfg_wdata;
				REG_KI:    ki_q    <= cfg_wdata;
				REG_KV:    kv_q    <= cfg_wdata;
				REG_KD:    kd_q    <= cfg_wdata;
				REG_RATED: rated_q <= cfg_wdata[14:0];
				REG_LEAD:  lead_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// one advance enable for the whole pipe: the output register is the only
	// place a beat can wait, so every stage moves when it frees up
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign adv           = !vld_s5 || drive_out.ready;
	assign tick_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= tick_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 1: input register
	logic signed [31:0] mpos_s1, mspd_s1, tpos_s1, tspd_s1;
	logic signed [15:0] tcur_s1;
	logic               clr_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			mpos_s1 <= tick_in.measured_position;
			mspd_s1 <= tick_in.measured_speed;
			tpos_s1 <= tick_in.target_position;
			tspd_s1 <= tick_in.target_speed;
			tcur_s1 <= tick_in.target_current;
			clr_s1  <= tick_in.clear_integral;
		end
	end

	// stage 2: errors, formed at full width then clamped
	logic signed [32:0] spd_diff, pos_diff;
	logic signed [25:0] vel_floor;
	logic signed [21:0] spd_err;
	logic signed [12:0] pos_err, vel_err;
	logic signed [21:0] err_a;
	logic signed [22:0] err_b;
	logic signed [21:0] err_prev_q;

	always_comb begin
		spd_diff  = 33'(tspd_s1) - 33'(mspd_s1);
		pos_diff  = 33'(tpos_s1) - 33'(mpos_s1);
		vel_floor = signed'(spd_diff[32:7]);
		spd_err   = 22'(sat_sym(43'(spd_diff), SPEED_ERR_LIMIT));
		pos_err   = 13'(sat_sym(43'(pos_diff), POS_ERR_LIMIT));
		vel_err   = 13'(sat_sym(43'(vel_floor), VEL_ERR_LIMIT));
		// speed mode: error and error difference; position mode: position and
		// velocity error, the latter feeding both integrator and derivative
		if (mode_q == MODE_SPEED) begin
			err_a = spd_err;
			err_b = 23'(spd_err) - 23'(err_prev_q);
		end else begin
			err_a = 22'(pos_err);
			err_b = 23'(vel_err);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_prev_q <= '0;
		end else if (adv && vld_s1 && mode_q == MODE_SPEED) begin
			err_prev_q <= spd_err;
		end
	end

	logic signed [21:0] err_a_s2;
	logic signed [22:0] err_b_s2;
	logic signed [31:0] mpos_s2;
	logic signed [15:0] tcur_s2;
	logic               clr_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			err_a_s2 <= err_a;
			err_b_s2 <= err_b;
			mpos_s2  <= mpos_s1;
			tcur_s2  <= tcur_s1;
			clr_s2   <= clr_s1;
		end
	end

	// stage 3: gain products
	logic signed [38:0] p_prod, ki_prod;
	logic signed [39:0] kv_prod, d_prod;
	logic signed [39:0] i_sum;

	always_comb begin
		p_prod  = 39'(signed'({1'b0, kp_q})) * 39'(err_a_s2);
		ki_prod = 39'(signed'({1'b0, ki_q})) * 39'(err_a_s2);
		kv_prod = 40'(signed'({1'b0, kv_q})) * 40'(err_b_s2);
		d_prod  = 40'(signed'({1'b0, kd_q})) * 40'(err_b_s2);
		// velocity term goes into the integrator in position mode only
		if (mode_q == MODE_POSITION) begin
			i_sum = 40'(ki_prod) + kv_prod;
		end else begin
			i_sum = 40'(ki_prod);
		end
	end

	logic signed [38:0] p_s3;
	logic signed [39:0] i_s3, d_s3;
	logic signed [31:0] mpos_s3;
	logic signed [15:0] tcur_s3;
	logic               clr_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3    <= p_prod;
			i_s3    <= i_sum;
			d_s3    <= d_prod;
			mpos_s3 <= mpos_s2;
			tcur_s3 <= tcur_s2;
			clr_s3  <= clr_s2;
		end
	end

	// stage 4: fractional integrator, state updated as the beat moves on
	scvc_int_ctl_t      int_ctl;
	logic signed [26:0] acc_next;

	assign int_ctl = '{adv: adv, vld: vld_s3, clr: clr_s3, mode: mode_q};

	scvc_integrator u_integrator (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (int_ctl),
		.rated    (rated_q),
		.incr     (i_s3),
		.acc_next (acc_next)
	);

	logic signed [38:0] p_s4;
	logic signed [39:0] d_s4;
	logic signed [26:0] acc_s4;
	logic signed [31:0] mpos_s4;
	logic signed [15:0] tcur_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4    <= p_s3;
			d_s4    <= d_s3;
			acc_s4  <= acc_next;
			mpos_s4 <= mpos_s3;
			tcur_s4 <= tcur_s3;
		end
	end

	// stage 5: law sum, flooring shift, current clamp, angle lead
	logic signed [41:0] law_sum;
	logic signed [31:0] law_shift;
	logic signed [15:0] cur;
	logic [15:0]        cur_abs;
	logic signed [31:0] angle;

	always_comb begin
		law_sum   = 42'(p_s4) + 42'(acc_s4) + 42'(d_s4);
		law_shift = signed'(law_sum[41:10]);
		case (mode_q) inside
			MODE_CURRENT:                cur = 16'(sat_sym(43'(tcur_s4), 25'(rated_q)));
			MODE_SPEED, MODE_POSITION:   cur = 16'(sat_sym(43'(law_shift), 25'(rated_q)));
			default:                     cur = '0;
		endcase
		cur_abs = cur[15] ? 16'(-cur) : 16'(cur);
		if (cur > 16'sd0) begin
			angle = mpos_s4 + signed'(32'(lead_q));
		end else if (cur < 16'sd0) begin
			angle = mpos_s4 - signed'(32'(lead_q));
		end else begin
			angle = mpos_s4;
		end
	end

	logic signed [15:0] cur_s5;
	logic signed [31:0] angle_s5;
	logic               at_limit_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			cur_s5      <= cur;
			angle_s5    <= angle;
			at_limit_s5 <= (cur_abs == 16'(rated_q));
		end
	end

	assign drive_out.valid            = vld_s5;
	assign drive_out.drive_current    = cur_s5;
	assign drive_out.electrical_angle = angle_s5;
	assign drive_out.at_limit         = at_limit_s5;

endmodule

// ===== design/scvc_checker.sv =====
module scvc_checker import scvc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] drive_current,
	input logic signed [31:0] electrical_angle,
	input logic               at_limit,
	input logic               cfg_we,
	input logic [2:0]         cfg_idx,
	input logic [15:0]        cfg_wdata
);

	logic [14:0] rated_q;
	logic [2:0]  inflight_q;
	logic [15:0] cur_abs;

	assign cur_abs = drive_current[15] ? 16'(-drive_current) : 16'(drive_current);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rated_q <= RATED_RESET;
		end else if (cfg_we && cfg_idx == REG_RATED) begin
			rated_q <= cfg_wdata[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
		end
	end

	// current never exceeds the rating
	a_cur_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cur_abs <= 16'(rated_q))
		else $error("drive current beyond rated current");

	// limit flag matches the magnitude
	a_limit_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (at_limit == (cur_abs == 16'(rated_q))))
		else $error("at_limit disagrees with drive current");

	// no result without an accepted input beat
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("result beat with nothing in flight");

	// input side only waits on a stalled output beat
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input stalled while output free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_current)
			&& $stable(electrical_angle) && $stable(at_limit))
		else $error("stalled result beat changed");

endmodule

bind stepper_current_vector_controller_top scvc_checker u_scvc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (tick_in.valid),
	.in_ready         (tick_in.ready),
	.out_valid        (drive_out.valid),
	.out_ready        (drive_out.ready),
	.drive_current    (drive_out.drive_current),
	.electrical_angle (drive_out.electrical_angle),
	.at_limit         (drive_out.at_limit),
	.cfg_we           (cfg_we),
	.cfg_idx          (cfg_idx),
	.cfg_wdata        (cfg_wdata)
);

// ===== verif/testbench.sv =====
module testbench;
	import scvc_pkg::*;

	// mode three is left unused by the block
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// directed setting profiles
	localparam logic [2:0] P_RESET  = 3'd0;
	localparam logic [2:0] P_WIDE   = 3'd1;
	localparam logic [2:0] P_SPEED  = 3'd2;
	localparam logic [2:0] P_POS    = 3'd3;
	localparam logic [2:0] P_SPARE  = 3'd4;
	localparam logic [2:0] P_ZERO   = 3'd5;
	localparam logic [2:0] P_GENTLE = 3'd6;

	// random part shape
	localparam int PHASES       = 13;
	localparam int PHASE_BEATS  = 72;
	localparam int STEADY_PHASE = 4;
	localparam int SPARE_PHASE  = 7;
	localparam int HOLD_PHASE   = 9;

	typedef struct packed {
		logic [31:0] mpos;
		logic [31:0] mspd;
		logic [31:0] tpos;
		logic [31:0] tspd;
		logic [15:0] tcur;
		logic        clr;
	} tick_t;

	typedef struct packed {
		logic [15:0] cur;
		logic [31:0] angle;
		logic        lim;
	} drive_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kv;
		logic [15:0] kd;
		logic [14:0] rated;
		logic [15:0] lead;
	} setting_t;

	typedef struct packed {
		logic [2:0] prof;
		tick_t      stim;
		logic       has_want;
		drive_t     want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [15:0] cfg_wdata;

	scvc_tick_if  tick_bus();
	scvc_drive_if drive_bus();

	stepper_current_vector_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.tick_in   (tick_bus),
		.drive_out (drive_bus)
	);

	// register mirror
	logic [1:0]  mode_r;
	logic [15:0] kp_r, ki_r, kv_r, kd_r, lead_r;
	logic [14:0] rated_r;

	// controller state mirror
	longint sp_err_last, sp_residue, sp_integ, ps_residue, ps_integ;

	// trajectory that the well-formed ticks follow
	logic [31:0] track_pos, track_spd;

	drive_t   drive_expected[$];
	row_t     plan [22];
	setting_t profiles [7];
	bit       steady;
	int       mismatches, results, limit_hits, clears;
	int       mode_beats [4];

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	function automatic longint clip(input longint x, input longint lim);
		if (x > lim) begin
			return lim;
		end else if (x < -lim) begin
			return -lim;
		end
		return x;
	endfunction

	// one control tick: updates the state mirror, returns the drive beat
	function automatic drive_t control_tick(input tick_t t);
		longint rated_l, acc_lim, cur, err, verr, frac, whole;
		drive_t d;
		logic [31:0] ang;
		rated_l = longint'(rated_r);
		acc_lim = rated_l * 1024;
		cur = 0;
		if (t.clr) begin
			sp_residue = 0;
			sp_integ = 0;
			ps_residue = 0;
			ps_integ = 0;
		end
		case (mode_r)
			MODE_CURRENT: begin
				cur = clip(longint'($signed(t.tcur)), rated_l);
			end
			MODE_SPEED: begin
				err = clip(longint'($signed(t.tspd)) - longint'($signed(t.mspd)),
					longint'(SPEED_ERR_LIMIT));
				// integrator keeps the low 10 bits as a nonnegative residue
				frac = sp_residue + longint'(ki_r) * err;
				whole = frac >>> 10;
				sp_residue = frac - (whole <<< 10);
				sp_integ = clip(sp_integ + whole, acc_lim);
				cur = clip((longint'(kp_r) * err + sp_integ
					+ longint'(kd_r) * (err - sp_err_last)) >>> 10, rated_l);
				sp_err_last = err;
			end
			MODE_POSITION: begin
				err = clip(longint'($signed(t.tpos)) - longint'($signed(t.mpos)),
					longint'(POS_ERR_LIMIT));
				// velocity error floors by 7 before its clamp
				verr = clip((longint'($signed(t.tspd)) - longint'($signed(t.mspd))) >>> 7,
					longint'(VEL_ERR_LIMIT));
				frac = ps_residue + longint'(ki_r) * err + longint'(kv_r) * verr;
				whole = frac >>> 7;
				ps_residue = frac - (whole <<< 7);
				ps_integ = clip(ps_integ + whole, acc_lim);
				cur = clip((longint'(kp_r) * err + ps_integ + longint'(kd_r) * verr) >>> 10,
					rated_l);
			end
			default: begin
				cur = 0;
			end
		endcase
		// lead follows the sign of the current, none at zero
		ang = t.mpos;
		if (cur > 0) begin
			ang = ang + {16'd0, lead_r};
		end else if (cur < 0) begin
			ang = ang - {16'd0, lead_r};
		end
		d.cur = 16'(cur);
		d.angle = ang;
		d.lim = ((cur < 0 ? -cur : cur) == rated_l);
		return d;
	endfunction

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// result beats taken at the rising edge, compared with the oldest prediction
	always @(posedge clk) begin : drive_check
		drive_t want;
		if (arst_n && drive_bus.valid && drive_bus.ready) begin
			if (drive_expected.size() == 0) begin
				report_mismatch("unexpected beat", 32'(drive_bus.drive_current),
					32'hx);
			end else begin
				want = drive_expected.pop_front();
				results++;
				if (drive_bus.at_limit === 1'b1) begin
					limit_hits++;
				end
				if (drive_bus.drive_current !== want.cur) begin
					report_mismatch("drive_current", 32'(drive_bus.drive_current),
						32'(want.cur));
				end
				if (drive_bus.electrical_angle !== want.angle) begin
					report_mismatch("electrical_angle", drive_bus.electrical_angle,
						want.angle);
				end
				if (drive_bus.at_limit !== want.lim) begin
					report_mismatch("at_limit", 32'(drive_bus.at_limit), 32'(want.lim));
				end
			end
		end
	end

	// receiver stalls at random, never inside the steady stretch
	always @(negedge clk) begin
		drive_bus.ready = steady || ($urandom_range(99) >= 35);
	end

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// one tick beat; prediction is taken at the accepting edge
	task automatic send_tick(input tick_t t, input logic has_want, input drive_t want);
		drive_t d;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 35) begin
			tick_bus.valid = 1'b0;
			@(negedge clk);
		end
		tick_bus.valid = 1'b1;
		tick_bus.measured_position = t.mpos;
		tick_bus.measured_speed = t.mspd;
		tick_bus.target_position = t.tpos;
		tick_bus.target_speed = t.tspd;
		tick_bus.target_current = t.tcur;
		tick_bus.clear_integral = t.clr;
		do begin
			@(posedge clk);
		end while (tick_bus.ready !== 1'b1);
		d = control_tick(t);
		// hand-typed values win where the table gives them
		drive_expected.push_back(has_want ? want : d);
		mode_beats[mode_r]++;
		if (t.clr) begin
			clears++;
		end
	endtask

	// drop valid right after the last beat and wait out every result
	task automatic quiet_and_drain();
		@(negedge clk);
		tick_bus.valid = 1'b0;
		while (drive_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = val;
		case (idx)
			REG_MODE:  mode_r = val[1:0];
			REG_KP:    kp_r = val;
			REG_KI:    ki_r = val;
			REG_KV:    kv_r = val;
			REG_KD:    kd_r = val;
			REG_RATED: rated_r = val[14:0];
			REG_LEAD:  lead_r = val;
			default: ;
		endcase
	endtask

	// full register set, written only once the block is idle
	task automatic apply_setting(input setting_t s);
		quiet_and_drain();
		write_reg(REG_MODE, {14'd0, s.mode});
		write_reg(REG_KP, s.kp);
		write_reg(REG_KI, s.ki);
		write_reg(REG_KV, s.kv);
		write_reg(REG_KD, s.kd);
		write_reg(REG_RATED, {1'b0, s.rated});
		write_reg(REG_LEAD, s.lead);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// random stimulus
	// ---------------------------------------------------------------

	// signed value with a random magnitude below 2^bits
	function automatic logic [31:0] near_value(input int unsigned bits);
		logic [31:0] mag;
		mag = $urandom() & ((32'd1 << bits) - 32'd1);
		return $urandom_range(1) ? -mag : mag;
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(255));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic setting_t random_setting(input int p);
		setting_t s;
		s.mode = (p == SPARE_PHASE) ? MODE_SPARE : 2'(p % 3);
		s.kp = pick_gain();
		s.ki = pick_gain();
		s.kv = pick_gain();
		s.kd = pick_gain();
		case ($urandom_range(3))
			0: s.rated = 15'd1;
			1: s.rated = 15'd32767;
			2: s.rated = 15'($urandom_range(400, 1));
			default: s.rated = 15'($urandom_range(32767, 1));
		endcase
		case ($urandom_range(3))
			0: s.lead = 16'd0;
			1: s.lead = 16'hFFFF;
			default: s.lead = 16'($urandom());
		endcase
		return s;
	endfunction

	// mostly a rotor following its targets closely, some wild noise
	function automatic tick_t random_tick();
		tick_t t;
		if ($urandom_range(99) < 20) begin
			t.mpos = $urandom();
			t.mspd = $urandom();
			t.tpos = $urandom();
			t.tspd = $urandom();
			t.tcur = 16'($urandom());
		end else begin
			track_spd = track_spd + near_value($urandom_range(12));
			track_pos = track_pos + near_value($urandom_range(12));
			t.tpos = track_pos;
			t.mpos = track_pos + near_value($urandom_range(13));
			t.tspd = track_spd;
			t.mspd = track_spd + near_value($urandom_range(22));
			t.tcur = 16'(near_value($urandom_range(15)));
		end
		t.clr = ($urandom_range(99) < 8);
		return t;
	endfunction

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin
		logic [2:0] cur_prof;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MODE;
		cfg_wdata = 16'd0;
		tick_bus.valid = 1'b0;
		tick_bus.measured_position = 32'd0;
		tick_bus.measured_speed = 32'd0;
		tick_bus.target_position = 32'd0;
		tick_bus.target_speed = 32'd0;
		tick_bus.target_current = 16'd0;
		tick_bus.clear_integral = 1'b0;
		drive_bus.ready = 1'b0;
		steady = 1'b0;
		track_pos = $urandom();
		track_spd = near_value(16);

		// mirror at its reset values
		mode_r = MODE_CURRENT;
		kp_r = 16'd0;
		ki_r = 16'd0;
		kv_r = 16'd0;
		kd_r = 16'd0;
		rated_r = RATED_RESET;
		lead_r = LEAD_RESET;
		sp_err_last = 0;
		sp_residue = 0;
		sp_integ = 0;
		ps_residue = 0;
		ps_integ = 0;

		profiles = '{
			'{MODE_CURRENT, 16'd0, 16'd0, 16'd0, 16'd0, RATED_RESET, LEAD_RESET},
			'{MODE_CURRENT, 16'd0, 16'd0, 16'd0, 16'd0, 15'd32767, 16'hFFFF},
			'{MODE_SPEED, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 15'd32767, 16'd4096},
			'{MODE_POSITION, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd32767, 16'd0},
			'{MODE_SPARE, 16'd100, 16'd100, 16'd100, 16'd100, 15'd3000, 16'd256},
			'{MODE_SPEED, 16'd1024, 16'd1024, 16'd0, 16'd0, 15'd0, 16'd777},
			'{MODE_POSITION, 16'd64, 16'd16, 16'd8, 16'd4, 15'd1, 16'd1}
		};

		// fields: mpos, mspd, tpos, tspd, tcur, clr
		plan = '{
			// straight after reset: passthrough, clamp at 3000, lead 256
			'{P_RESET, '{32'h0, 32'h0, 32'h0, 32'h0, 16'd100, 1'b0},
				1'b1, '{16'd100, 32'h100, 1'b0}},
			'{P_RESET, '{32'd1000, 32'h0, 32'h0, 32'h0, 16'h7FFF, 1'b0},
				1'b1, '{16'd3000, 32'd1256, 1'b1}},
			'{P_RESET, '{32'h0, 32'h0, 32'h0, 32'h0, 16'h8000, 1'b0},
				1'b1, '{16'hF448, 32'hFFFFFF00, 1'b1}},
			'{P_RESET, '{32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0},
				1'b1, '{16'h0, 32'h7FFFFFFF, 1'b0}},
			'{P_RESET, '{32'h80000000, 32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b0},
				1'b1, '{16'hFFFF, 32'h7FFFFF00, 1'b0}},
			// widest rating and lead, angle wraps both ways
			'{P_WIDE, '{32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 16'h7FFF, 1'b0},
				1'b1, '{16'h7FFF, 32'h8000FFFE, 1'b1}},
			'{P_WIDE, '{32'h80000000, 32'h0, 32'h0, 32'h0, 16'h8000, 1'b0},
				1'b1, '{16'h8001, 32'h7FFF0001, 1'b1}},
			'{P_WIDE, '{32'h0, 32'h0, 32'h0, 32'h0, 16'd3000, 1'b1},
				1'b1, '{16'd3000, 32'h0000FFFF, 1'b0}},
			// speed loop at full gains, error clamps both ways
			'{P_SPEED, '{32'h0, 32'h80000000, 32'h0, 32'h7FFFFFFF, 16'h0, 1'b0}, 1'b0, '0},
			'{P_SPEED, '{32'h0, 32'h7FFFFFFF, 32'h0, 32'h80000000, 16'h0, 1'b0}, 1'b0, '0},
			'{P_SPEED, '{32'h0, 32'h0, 32'h0, 32'd5, 16'h0, 1'b0}, 1'b0, '0},
			'{P_SPEED, '{32'h0, 32'h0, 32'h0, 32'd5, 16'h0, 1'b1}, 1'b0, '0},
			'{P_SPEED, '{32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0}, 1'b0, '0},
			// position law, position and velocity errors at their clamps
			'{P_POS, '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0, 1'b0},
				1'b0, '0},
			'{P_POS, '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 16'h0, 1'b0},
				1'b0, '0},
			'{P_POS, '{32'h0, 32'h0, 32'd100, 32'd255, 16'h0, 1'b1}, 1'b0, '0},
			// velocity error floors toward minus infinity
			'{P_POS, '{32'h0, 32'h0, 32'h0, 32'hFFFFFF7F, 16'h0, 1'b0}, 1'b0, '0},
			// unused mode: no current, bare position
			'{P_SPARE, '{32'd5, 32'h0, 32'h0, 32'h0, 16'd1000, 1'b0},
				1'b1, '{16'h0, 32'd5, 1'b0}},
			'{P_SPARE, '{32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 16'hFFFB, 1'b1},
				1'b1, '{16'h0, 32'hFFFFFFFF, 1'b0}},
			// zero rating: current pinned at zero, always at the limit
			'{P_ZERO, '{32'd42, 32'h0, 32'h0, 32'd1000, 16'd500, 1'b0},
				1'b1, '{16'h0, 32'd42, 1'b1}},
			// rating of one with gentle gains
			'{P_GENTLE, '{32'h0, 32'h0, 32'd3200, 32'h0, 16'h0, 1'b0}, 1'b0, '0},
			'{P_GENTLE, '{32'h0, 32'h0, 32'hFFFFF37F, 32'h0, 16'h0, 1'b1}, 1'b0, '0}
		};

		// reset once, released on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		cur_prof = P_RESET;
		foreach (plan[i]) begin
			if (plan[i].prof != cur_prof) begin
				cur_prof = plan[i].prof;
				apply_setting(profiles[cur_prof]);
			end
			send_tick(plan[i].stim, plan[i].has_want, plan[i].want);
		end

		// random phases, one setting each
		for (int p = 0; p < PHASES; p++) begin
			apply_setting(random_setting(p));
			steady = (p == STEADY_PHASE);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				// sender holds off until the pipeline is empty
				if (p == HOLD_PHASE && n == PHASE_BEATS / 2) begin
					quiet_and_drain();
				end
				send_tick(random_tick(), 1'b0, '0);
			end
			steady = 1'b0;
		end

		// let the last beats out, then a short watch for stray results
		quiet_and_drain();
		repeat (12) @(posedge clk);

		$display("covered %0d ticks: current %0d, speed %0d, position %0d, unused %0d; %0d cleared",
			mode_beats[0] + mode_beats[1] + mode_beats[2] + mode_beats[3],
			mode_beats[0], mode_beats[1], mode_beats[2], mode_beats[3], clears);
		$display("%0d drive beats checked, %0d at the current limit, %0d mismatches",
			results, limit_hits, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#4000000;
		$display("timeout with %0d drive beats still outstanding", drive_expected.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
